### hw/rtl/pip_pkg.sv
// Shared types and constants for the even-odd point-in-polygon block.
// No dependencies; used by every module under hw/rtl.
package pip_pkg;

	localparam int MAX_VERTICES   = 64;
	localparam int COORD_BITS     = 16;
	localparam int MIN_POLY_VERTS = 3;

	localparam int ADDR_BITS = $clog2(MAX_VERTICES);
	localparam int CNT_BITS  = 7;   // vertex_count field width, holds 0..MAX_VERTICES
	localparam int DIFF_BITS = COORD_BITS + 1;
	localparam int PROD_BITS = 2 * DIFF_BITS;

	localparam int ACT_BITS      = 2;
	localparam int IN_DATA_BITS  = ((2 * COORD_BITS + 7) / 8) * 8;
	localparam int OUT_DATA_BITS = ((2 + CNT_BITS + 7) / 8) * 8;

	localparam logic [ACT_BITS-1:0] ACT_START  = 2'd0;
	localparam logic [ACT_BITS-1:0] ACT_APPEND = 2'd1;
	localparam logic [ACT_BITS-1:0] ACT_QUERY  = 2'd2;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] y;
		logic signed [COORD_BITS-1:0] x;
	} vert_t;

	// one edge of the ring: vertex i and its predecessor j
	typedef struct packed {
		logic  vld;
		vert_t vi;
		vert_t vj;
	} edge_t;

	typedef struct packed {
		logic busy;
		logic flip;
	} edge_st_t;

endpackage

### hw/rtl/pip_vstore.sv
// Vertex store: single-port-write, single-port-read memory, registered read.
// Depends on pip_pkg for the vertex type and depth.
module pip_vstore (
	input  logic                          clk,
	input  logic                          wr_en,
	input  logic [pip_pkg::ADDR_BITS-1:0] wr_addr,
	input  pip_pkg::vert_t                wr_data,
	input  logic                          rd_en,
	input  logic [pip_pkg::ADDR_BITS-1:0] rd_addr,
	output pip_pkg::vert_t                rd_data
);

	pip_pkg::vert_t mem [pip_pkg::MAX_VERTICES];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

### hw/rtl/pip_edge.sv
// Crossing test for one edge a cycle: differences, products, then compare.
// Depends on pip_pkg; fed by the vertex walk in the top level.
module pip_edge (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  pip_pkg::edge_t                       edge_in,
	input  logic signed [pip_pkg::COORD_BITS-1:0] px,
	input  logic signed [pip_pkg::COORD_BITS-1:0] py,
	output pip_pkg::edge_st_t                    st
);

	localparam int CB = pip_pkg::COORD_BITS;
	localparam int DB = pip_pkg::DIFF_BITS;
	localparam int PB = pip_pkg::PROD_BITS;

	logic signed [CB-1:0] xi, yi, xj, yj;
	logic                 crosses;

	logic                 v_s2, dypos_s2;
	logic signed [DB-1:0] dxp_s2, dy_s2, dxe_s2, dyp_s2;
	logic                 v_s3, dypos_s3;
	logic signed [PB-1:0] lhs_s3, rhs_s3;

	assign xi = edge_in.vi.x;
	assign yi = edge_in.vi.y;
	assign xj = edge_in.vj.x;
	assign yj = edge_in.vj.y;
	assign crosses = ($signed(yi) > $signed(py)) != ($signed(yj) > $signed(py));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s2 <= edge_in.vld && crosses;
			v_s3 <= v_s2;
		end
	end

	// 17-bit differences; a crossing edge implies dy is non-zero
	always_ff @(posedge clk) begin
		dxp_s2   <= $signed({px[CB-1], px}) - $signed({xi[CB-1], xi});
		dy_s2    <= $signed({yj[CB-1], yj}) - $signed({yi[CB-1], yi});
		dxe_s2   <= $signed({xj[CB-1], xj}) - $signed({xi[CB-1], xi});
		dyp_s2   <= $signed({py[CB-1], py}) - $signed({yi[CB-1], yi});
		dypos_s2 <= $signed(yj) > $signed(yi);
		lhs_s3   <= dxp_s2 * dy_s2;
		rhs_s3   <= dxe_s2 * dyp_s2;
		dypos_s3 <= dypos_s2;
	end

	assign st.busy = v_s2 || v_s3;
	assign st.flip = v_s3 && (dypos_s3 ? (lhs_s3 < rhs_s3) : (lhs_s3 > rhs_s3));

endmodule

### hw/rtl/point_in_polygon_even_odd.sv
// Even-odd point-in-polygon block. Vertex beats (start, append), unused codes and queries
// over fewer than three vertices have their result registered on acceptance. A query
// over n >= 3 vertices makes n + 1 reads of the vertex store's single read port, then the
// crossing pipeline drains. One item is worked on at a time; a two-deep output buffer
// lets the next beat in while one result waits. Reset clears the vertex count and
// control; store contents stay undefined and need no clearing pass.
module point_in_polygon_even_odd (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [pip_pkg::IN_DATA_BITS-1:0]   s_tdata,  // coord_x, coord_y
	input  logic [pip_pkg::ACT_BITS-1:0]       s_tuser,  // action
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [pip_pkg::OUT_DATA_BITS-1:0]  m_tdata   // inside_res, vertex_count, dropped
);

	localparam int CB = pip_pkg::COORD_BITS;
	localparam int AW = pip_pkg::ADDR_BITS;
	localparam int NB = pip_pkg::CNT_BITS;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_WALK  = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;

	logic [1:0]           state_q;
	logic [AW-1:0]        idx_q;
	logic [NB-1:0]        count_q;
	logic signed [CB-1:0] px_q, py_q;
	logic                 inside_q;
	logic                 rd_vld_s1, rd_first_s1;
	pip_pkg::vert_t       prev_q;

	logic                 out_vld_q, out_inside_q, out_drop_q;
	logic [NB-1:0]        out_count_q;
	logic                 skid_vld_q, skid_inside_q, skid_drop_q;
	logic [NB-1:0]        skid_count_q;

	logic                 acc, pop, walk_start, drain_done;
	logic                 res_push, res_inside, res_drop;
	logic [NB-1:0]        res_count;
	logic                 wr_en, rd_en;
	logic [AW-1:0]        wr_addr, rd_addr;
	logic [NB-1:0]        last_cnt;
	pip_pkg::vert_t       in_vert, rd_data;
	pip_pkg::edge_t       edge_in;
	pip_pkg::edge_st_t    edge_st;
	logic [pip_pkg::ACT_BITS-1:0] action;

	assign action    = s_tuser;
	assign in_vert.x = s_tdata[CB-1:0];
	assign in_vert.y = s_tdata[2*CB-1:CB];

	assign pop      = out_vld_q && m_tready;
	assign s_tready = (state_q == ST_IDLE) && !skid_vld_q;
	assign acc      = s_tvalid && s_tready;
	assign last_cnt = count_q - NB'(1);

	assign walk_start = acc && (action == pip_pkg::ACT_QUERY)
	                    && (count_q >= NB'(pip_pkg::MIN_POLY_VERTS));

	assign drain_done = (state_q == ST_DRAIN) && !rd_vld_s1 && !edge_st.busy
	                    && !skid_vld_q;
	assign res_push   = (acc && !walk_start) || drain_done;

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = '0;
		if (acc) begin
			case (action)
				pip_pkg::ACT_START: begin
					wr_en = 1'b1;
				end
				pip_pkg::ACT_APPEND: begin
					wr_en   = count_q < NB'(pip_pkg::MAX_VERTICES);
					wr_addr = count_q[AW-1:0];
				end
				default: begin
					wr_en = 1'b0;
				end
			endcase
		end
	end

	// result for the beat being taken, or for the query finishing
	always_comb begin
		res_inside = drain_done && inside_q;
		res_drop   = 1'b0;
		res_count  = count_q;
		if (acc) begin
			case (action)
				pip_pkg::ACT_START: begin
					res_count = NB'(1);
				end
				pip_pkg::ACT_APPEND: begin
					if (count_q < NB'(pip_pkg::MAX_VERTICES)) begin
						res_count = count_q + NB'(1);
					end else begin
						res_drop = 1'b1;
					end
				end
				default: begin
					res_count = count_q;
				end
			endcase
		end
	end

	// first read fetches the closing vertex n-1, then 0..n-1
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = idx_q;
		if (walk_start) begin
			rd_en   = 1'b1;
			rd_addr = last_cnt[AW-1:0];
		end else if (state_q == ST_WALK) begin
			rd_en = 1'b1;
		end
	end

	pip_vstore u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (in_vert),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign edge_in.vld = rd_vld_s1 && !rd_first_s1;
	assign edge_in.vi  = rd_data;
	assign edge_in.vj  = prev_q;

	pip_edge u_edge (
		.clk     (clk),
		.arst_n  (arst_n),
		.edge_in (edge_in),
		.px      (px_q),
		.py      (py_q),
		.st      (edge_st)
	);

	always_ff @(posedge clk) begin
		if (rd_vld_s1) begin
			prev_q <= rd_data;
		end
		if (walk_start) begin
			px_q <= in_vert.x;
			py_q <= in_vert.y;
		end
		// head register takes the skid entry first, keeping results in order
		if (!out_vld_q || pop) begin
			if (skid_vld_q) begin
				out_inside_q <= skid_inside_q;
				out_drop_q   <= skid_drop_q;
				out_count_q  <= skid_count_q;
			end else if (res_push) begin
				out_inside_q <= res_inside;
				out_drop_q   <= res_drop;
				out_count_q  <= res_count;
			end
		end
		if (res_push && out_vld_q && (!pop || skid_vld_q)) begin
			skid_inside_q <= res_inside;
			skid_drop_q   <= res_drop;
			skid_count_q  <= res_count;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			count_q     <= '0;
			inside_q    <= 1'b0;
			rd_vld_s1   <= 1'b0;
			rd_first_s1 <= 1'b0;
			out_vld_q   <= 1'b0;
			skid_vld_q  <= 1'b0;
		end else begin
			rd_vld_s1   <= rd_en;
			rd_first_s1 <= walk_start;
			if (edge_st.flip) begin
				inside_q <= !inside_q;
			end
			out_vld_q  <= (out_vld_q && !pop) || skid_vld_q || res_push;
			skid_vld_q <= (res_push && out_vld_q && (!pop || skid_vld_q))
			              || (skid_vld_q && !pop);
			case (state_q)
				ST_IDLE: begin
					if (acc) begin
						if (action == pip_pkg::ACT_START) begin
							count_q <= NB'(1);
						end else if (action == pip_pkg::ACT_APPEND
						             && count_q < NB'(pip_pkg::MAX_VERTICES)) begin
							count_q <= count_q + NB'(1);
						end
						if (walk_start) begin
							idx_q    <= '0;
							inside_q <= 1'b0;
							state_q  <= ST_WALK;
						end
					end
				end
				ST_WALK: begin
					idx_q <= idx_q + AW'(1);
					if ({1'b0, idx_q} == last_cnt) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (drain_done) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {{(pip_pkg::OUT_DATA_BITS - NB - 2){1'b0}},
	                   out_drop_q, out_count_q, out_inside_q};

`ifndef NO_ASSERTIONS
	// the crossing pipeline is empty whenever a new beat can be taken
	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (!rd_vld_s1 && !edge_st.busy))
		else $error("edge pipeline busy while idle");

	// a drop is only reported with the store full
	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[NB+1]) |-> (m_tdata[NB:1] == NB'(pip_pkg::MAX_VERTICES)))
		else $error("drop reported below capacity");

	// inside only with a proper polygon
	a_inside_poly: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[0]) |-> (m_tdata[NB:1] >= NB'(pip_pkg::MIN_POLY_VERTS)))
		else $error("inside reported for a degenerate polygon");

	// count never exceeds capacity
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> (count_q <= NB'(pip_pkg::MAX_VERTICES)))
		else $error("vertex count past capacity");
`endif

endmodule
